// ----- design/vkf_pkg.sv -----
`timescale 1ns / 1ps
package vkf_pkg;

	localparam int WORD_MAX = 32;
	localparam int KEY_MAX  = 3;
	localparam int ALPHA    = 26;

	localparam int IDX_W     = $clog2(WORD_MAX);
	localparam int LEN_W     = $clog2(WORD_MAX + 1);
	localparam int KEY_LEN_W = 2;
	localparam int DSEL_W    = 2;
	localparam int SHIFT_W   = 5;
	localparam int BM_DEPTH  = ALPHA * ALPHA;
	localparam int BM_AW     = $clog2(BM_DEPTH);
	localparam int PROD_W    = $clog2(128 * (WORD_MAX + 1));

	localparam logic [7:0] CHAR_A = 8'd97;
	localparam logic [7:0] CHAR_Z = 8'd122;
	localparam logic [7:0] CHAR_E = 8'd101;
	localparam logic [7:0] CHAR_I = 8'd105;
	localparam logic [7:0] CHAR_O = 8'd111;
	localparam logic [7:0] CHAR_U = 8'd117;
	localparam logic [7:0] CHAR_K = 8'd107;
	localparam logic [7:0] CHAR_W = 8'd119;
	localparam logic [7:0] CHAR_Y = 8'd121;

	localparam logic [SHIFT_W-1:0] SHIFT_LAST = 5'd25;

	localparam logic [1:0] ACT_MARK = 2'd0;
	localparam logic [1:0] ACT_LOAD = 2'd1;
	localparam logic [1:0] ACT_TRY  = 2'd2;

	typedef enum logic [2:0] {
		V_PASS = 3'd0,
		V_KWY  = 3'd1,
		V_FEW  = 3'd2,
		V_BIG  = 3'd3,
		V_EXH  = 3'd4
	} verdict_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_SCAN,
		ST_VERD,
		ST_LRD,
		ST_LOUT
	} state_t;

	typedef struct packed {
		logic [KEY_MAX-1:0][SHIFT_W-1:0] digit;
		logic [KEY_LEN_W-1:0]            len;
		logic                            exhausted;
	} key_t;

	typedef struct packed {
		logic step;
		logic clear;
	} key_ctl_t;

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= CHAR_A) && (c <= CHAR_Z);
	endfunction

	function automatic logic [7:0] shift_byte(input logic [7:0] c,
			input logic [SHIFT_W-1:0] s);
		logic [5:0] sum;
		sum = 6'(c - CHAR_A) + 6'(s);
		if (sum >= 6'(ALPHA))
			sum = sum - 6'(ALPHA);
		return is_lower(c) ? (8'(sum) + CHAR_A) : c;
	endfunction

	function automatic logic is_vowel(input logic [7:0] c);
		return (c == CHAR_A) || (c == CHAR_E) || (c == CHAR_I) || (c == CHAR_O) ||
			(c == CHAR_U);
	endfunction

	function automatic logic is_kwy(input logic [7:0] c);
		return (c == CHAR_K) || (c == CHAR_W) || (c == CHAR_Y);
	endfunction

endpackage

// ----- design/vkf_ram.sv -----
`timescale 1ns / 1ps
module vkf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ----- design/vkf_key.sv -----
`timescale 1ns / 1ps
module vkf_key (
	input  logic              clk,
	input  logic              arst_n,
	input  vkf_pkg::key_ctl_t ctl,
	output vkf_pkg::key_t     key,
	output logic              try_exh
);
	import vkf_pkg::*;

	key_t key_q, key_nx;
	logic carry;

	// counting order, last active digit fastest; full wrap grows length, or at max sets exhausted
	always_comb begin
		key_nx = key_q;
		carry  = 1'b1;
		if (key_q.len == '0) begin
			key_nx.len   = KEY_LEN_W'(1);
			key_nx.digit = '0;
			carry        = 1'b0;
		end else begin
			for (int j = KEY_MAX - 1; j >= 0; j--) begin
				if (KEY_LEN_W'(j) < key_q.len && carry) begin
					if (key_q.digit[j] < SHIFT_LAST) begin
						key_nx.digit[j] = key_q.digit[j] + SHIFT_W'(1);
						carry           = 1'b0;
					end else begin
						key_nx.digit[j] = '0;
					end
				end
			end
			if (carry) begin
				if (key_q.len >= KEY_LEN_W'(KEY_MAX)) begin
					key_nx.exhausted = 1'b1;
				end else begin
					key_nx.len   = key_q.len + KEY_LEN_W'(1);
					key_nx.digit = '0;
				end
			end
		end
		if (key_q.exhausted)
			key_nx = key_q;
	end

	assign try_exh = key_nx.exhausted;
	assign key     = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (ctl.clear) begin
			key_q <= '0;
		end else if (ctl.step) begin
			key_q <= key_nx;
		end
	end

endmodule

// ----- design/vigenere_key_search_filter_core.sv -----
`timescale 1ns / 1ps
// Brute-force Vigenere key search with letter filters.
// Input channel (in_valid/in_ready) carries one request per beat: mark or clear a
// forbidden bigram, append a ciphertext byte to the word buffer, or try the next
// key. Mark and load beats give no result, and the input stays ready after them.
// A try beat steps the key counter and, unless the keys are exhausted, walks the
// buffered word through the cipher buffer RAM and the bigram bitmap RAM, one
// letter a cycle, then gives the verdict. On a pass the letters follow, each
// re-read from the buffer RAM.
// Output channel (out_valid/out_ready) is one result register: kind 0 is the
// verdict, kind 1 a candidate letter, last marks the final beat of a try.
// When the receiver stalls, the walk stops at the next result that needs the
// register; the input is taken again as soon as the final result is loaded.
// Reset: after arst_n releases, all 676 bigram bitmap entries are swept to zero,
// one entry a cycle; in_ready stays low meanwhile. cfg_we/cfg_wdata write the
// vowel percentage (reset 33) at any clock edge.
module vigenere_key_search_filter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic [4:0]                   bigram_first,
	input  logic [4:0]                   bigram_second,
	input  logic                         mark,
	input  logic [7:0]                   cipher_letter,
	input  logic                         word_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         kind,
	output logic [2:0]                   verdict,
	output logic [vkf_pkg::SHIFT_W-1:0]  shift_one,
	output logic [vkf_pkg::SHIFT_W-1:0]  shift_two,
	output logic [vkf_pkg::SHIFT_W-1:0]  shift_three,
	output logic [vkf_pkg::KEY_LEN_W-1:0] key_length,
	output logic [7:0]                   plain_letter,
	output logic                         last,
	input  logic                         cfg_we,
	input  logic [6:0]                   cfg_wdata
);
	import vkf_pkg::*;

	state_t state_q, state_d;

	logic [6:0]       vpct_q;
	logic [LEN_W-1:0] len_q;
	logic             restart_q;
	logic [BM_AW-1:0] clr_q;

	logic [LEN_W-1:0]  idx_q;
	logic [DSEL_W-1:0] dsel_q;
	logic              v_s1, first_s1, bchk_s2;
	logic [DSEL_W-1:0] dsel_s1;
	logic [7:0]        prev_q;
	logic              kwy_q, big_q;
	logic [LEN_W-1:0]  vow_q;

	logic             out_valid_q, kind_q, last_q;
	verdict_t         verdict_q;
	logic [SHIFT_W-1:0] sh1_q, sh2_q, sh3_q;
	logic [KEY_LEN_W-1:0] klen_q;
	logic [7:0]       plain_q;

	key_t     key;
	key_ctl_t key_ctl;
	logic     try_exh;

	logic             acc, acc_mark, acc_load, acc_try;
	logic             out_free;
	logic [LEN_W-1:0] eff_len;

	logic             buf_we, buf_re;
	logic [IDX_W-1:0] buf_waddr, buf_raddr;
	logic [7:0]       buf_rdata;

	logic             bm_we, bm_wdata, bm_re, bm_rdata;
	logic [BM_AW-1:0] bm_waddr, bm_raddr;

	logic [7:0]         plain_c, let_c;
	logic               big_chk;
	logic [PROD_W-1:0]  vow_lhs, vow_rhs;
	verdict_t           verd_c;
	logic               scan_issue, scan_done, let_last;
	logic [DSEL_W-1:0]  dsel_adv;

	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;
	assign acc_mark = acc && (action == ACT_MARK);
	assign acc_load = acc && (action == ACT_LOAD);
	assign acc_try  = acc && (action == ACT_TRY);
	assign out_free = !out_valid_q || out_ready;

	assign key_ctl.clear = acc_load && restart_q;
	assign key_ctl.step  = acc_try;

	vkf_key u_key (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (key_ctl),
		.key     (key),
		.try_exh (try_exh)
	);

	// cipher word buffer
	assign eff_len   = restart_q ? '0 : len_q;
	assign buf_we    = acc_load && (eff_len < LEN_W'(WORD_MAX));
	assign buf_waddr = eff_len[IDX_W-1:0];
	assign scan_issue = (state_q == ST_SCAN) && (idx_q < len_q);
	assign buf_re    = scan_issue || (state_q == ST_LRD);
	assign buf_raddr = idx_q[IDX_W-1:0];

	vkf_ram #(.WIDTH(8), .DEPTH(WORD_MAX)) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (cipher_letter),
		.re    (buf_re),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	// forbidden bigram bitmap: swept clear after reset, then written by mark beats
	always_comb begin
		bm_we    = 1'b0;
		bm_waddr = clr_q;
		bm_wdata = 1'b0;
		if (state_q == ST_CLR) begin
			bm_we = 1'b1;
		end else if (acc_mark && (bigram_first < 5'(ALPHA)) &&
				(bigram_second < 5'(ALPHA))) begin
			bm_we    = 1'b1;
			bm_waddr = BM_AW'(bigram_first) * BM_AW'(ALPHA) + BM_AW'(bigram_second);
			bm_wdata = mark;
		end
	end

	assign plain_c  = shift_byte(buf_rdata, key.digit[dsel_s1]);
	assign big_chk  = v_s1 && !first_s1 && is_lower(prev_q) && is_lower(plain_c);
	assign bm_re    = big_chk;
	assign bm_raddr = BM_AW'(5'(prev_q - CHAR_A)) * BM_AW'(ALPHA) +
		BM_AW'(5'(plain_c - CHAR_A));

	vkf_ram #(.WIDTH(1), .DEPTH(BM_DEPTH)) u_bm (
		.clk   (clk),
		.we    (bm_we),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.re    (bm_re),
		.raddr (bm_raddr),
		.rdata (bm_rdata)
	);

	assign scan_done = (idx_q == len_q) && !v_s1 && !bchk_s2;
	assign dsel_adv  = (DSEL_W'(key.len) - DSEL_W'(1) == dsel_q) ? '0 :
		dsel_q + DSEL_W'(1);
	assign let_c     = shift_byte(buf_rdata, key.digit[dsel_q]);
	assign let_last  = (idx_q + LEN_W'(1) == len_q);

	assign vow_lhs = PROD_W'(vow_q) * PROD_W'(100);
	assign vow_rhs = PROD_W'(vpct_q) * PROD_W'(len_q);

	always_comb begin
		if (key.exhausted)
			verd_c = V_EXH;
		else if (kwy_q)
			verd_c = V_KWY;
		else if (vow_lhs <= vow_rhs)
			verd_c = V_FEW;
		else if (big_q)
			verd_c = V_BIG;
		else
			verd_c = V_PASS;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR: begin
				if (clr_q == BM_AW'(BM_DEPTH - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc_try)
					state_d = try_exh ? ST_VERD : ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_done)
					state_d = ST_VERD;
			end
			ST_VERD: begin
				if (out_free)
					state_d = (verd_c == V_PASS && len_q != '0) ? ST_LRD : ST_IDLE;
			end
			ST_LRD: begin
				state_d = ST_LOUT;
			end
			ST_LOUT: begin
				if (out_free)
					state_d = let_last ? ST_IDLE : ST_LRD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLR;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpct_q    <= 7'd33;
			len_q     <= '0;
			restart_q <= 1'b1;
			clr_q     <= '0;
			v_s1      <= 1'b0;
			bchk_s2   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				vpct_q <= cfg_wdata;
			if (state_q == ST_CLR)
				clr_q <= clr_q + BM_AW'(1);
			if (acc_load) begin
				len_q     <= buf_we ? eff_len + LEN_W'(1) : eff_len;
				restart_q <= word_end;
			end
			v_s1    <= scan_issue;
			bchk_s2 <= big_chk;
			if ((state_q == ST_VERD || state_q == ST_LOUT) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// walk datapath and result register
	always_ff @(posedge clk) begin
		if (acc_try) begin
			idx_q  <= '0;
			dsel_q <= '0;
			kwy_q  <= 1'b0;
			big_q  <= 1'b0;
			vow_q  <= '0;
		end
		if (scan_issue) begin
			idx_q    <= idx_q + LEN_W'(1);
			dsel_q   <= dsel_adv;
			dsel_s1  <= dsel_q;
			first_s1 <= (idx_q == '0);
		end
		if (v_s1) begin
			prev_q <= plain_c;
			if (is_kwy(plain_c))
				kwy_q <= 1'b1;
			if (is_vowel(plain_c))
				vow_q <= vow_q + LEN_W'(1);
		end
		if (bchk_s2 && bm_rdata)
			big_q <= 1'b1;

		if (state_q == ST_VERD && out_free) begin
			kind_q    <= 1'b0;
			verdict_q <= verd_c;
			plain_q   <= '0;
			last_q    <= (verd_c != V_PASS) || (len_q == '0);
			idx_q     <= '0;
			dsel_q    <= '0;
			sh1_q     <= key.exhausted ? '0 : key.digit[0];
			sh2_q     <= (!key.exhausted && key.len > KEY_LEN_W'(1)) ? key.digit[1] : '0;
			sh3_q     <= (!key.exhausted && key.len > KEY_LEN_W'(2)) ? key.digit[2] : '0;
			klen_q    <= key.exhausted ? '0 : key.len;
		end
		if (state_q == ST_LOUT && out_free) begin
			kind_q    <= 1'b1;
			verdict_q <= V_PASS;
			plain_q   <= let_c;
			last_q    <= let_last;
			idx_q     <= idx_q + LEN_W'(1);
			dsel_q    <= dsel_adv;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign verdict      = verdict_q;
	assign shift_one    = sh1_q;
	assign shift_two    = sh2_q;
	assign shift_three  = sh3_q;
	assign key_length   = klen_q;
	assign plain_letter = plain_q;
	assign last         = last_q;

endmodule
